>>> design/gbmw_pkg.sv
package gbmw_pkg;

   localparam int unsigned DATA_W = 32;
   localparam int unsigned HALF_W = 16;
   localparam int unsigned ADDR_W = 7;
   localparam int unsigned OP_W   = 2;

   localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
   localparam logic [OP_W-1:0] OP_READ  = 2'd1;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd2;

   localparam logic [ADDR_W-1:0] ADDR_OUT_LEVEL  = 7'h00;
   localparam logic [ADDR_W-1:0] ADDR_DIRECTION  = 7'h08;
   localparam logic [ADDR_W-1:0] ADDR_IRQ_ENABLE = 7'h10;
   localparam logic [ADDR_W-1:0] ADDR_IRQ_MASK   = 7'h18;
   localparam logic [ADDR_W-1:0] ADDR_EDGE_TYPE  = 7'h20;
   localparam logic [ADDR_W-1:0] ADDR_POLARITY   = 7'h28;
   localparam logic [ADDR_W-1:0] ADDR_BOTH_EDGES = 7'h30;
   localparam logic [ADDR_W-1:0] ADDR_STATUS     = 7'h50;
   localparam logic [ADDR_W-1:0] ADDR_RAW_STATUS = 7'h58;
   localparam logic [ADDR_W-1:0] ADDR_EOI        = 7'h60;
   localparam logic [ADDR_W-1:0] ADDR_PINS       = 7'h70;
   localparam logic [ADDR_W-1:0] ADDR_VERSION    = 7'h78;

   localparam logic [DATA_W-1:0] VERSION_WORD = 32'h01000c2b;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [ADDR_W-1:0] address;
      logic [DATA_W-1:0] write_data;
      logic [DATA_W-1:0] pin_in;
   } req_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_data;
      logic [DATA_W-1:0] pin_out;
      logic [DATA_W-1:0] pin_dir;
      logic              irq;
   } rsp_type;

endpackage

>>> design/gbmw_core.sv
module gbmw_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  gbmw_pkg::req_type item,
   output gbmw_pkg::rsp_type result
);

   logic [gbmw_pkg::DATA_W-1:0] out_level_ff, out_level_in;
   logic [gbmw_pkg::DATA_W-1:0] direction_ff, direction_in;
   logic [gbmw_pkg::DATA_W-1:0] irq_enable_ff, irq_enable_in;
   logic [gbmw_pkg::DATA_W-1:0] irq_mask_ff, irq_mask_in;
   logic [gbmw_pkg::DATA_W-1:0] edge_type_ff, edge_type_in;
   logic [gbmw_pkg::DATA_W-1:0] polarity_ff, polarity_in;
   logic [gbmw_pkg::DATA_W-1:0] both_edges_ff, both_edges_in;
   logic [gbmw_pkg::DATA_W-1:0] edge_latched_ff, edge_latched_in;
   logic [gbmw_pkg::DATA_W-1:0] previous_pins_ff, previous_pins_in;

   logic [gbmw_pkg::ADDR_W-1:0] base_addr;
   logic                        aligned;
   logic                        is_write;
   logic [gbmw_pkg::DATA_W-1:0] we;
   logic [gbmw_pkg::DATA_W-1:0] wdata;
   logic [gbmw_pkg::DATA_W-1:0] old_raw;
   logic [gbmw_pkg::DATA_W-1:0] half_word;
   logic [gbmw_pkg::DATA_W-1:0] read_value;
   logic [gbmw_pkg::DATA_W-1:0] eoi_cleared;
   logic [gbmw_pkg::DATA_W-1:0] rise, fall, hits;
   logic [gbmw_pkg::DATA_W-1:0] new_edge_pins;
   logic [gbmw_pkg::DATA_W-1:0] new_raw;

   function automatic logic [gbmw_pkg::DATA_W-1:0] raw_status(
      input logic [gbmw_pkg::DATA_W-1:0] pins,
      input logic [gbmw_pkg::DATA_W-1:0] enable,
      input logic [gbmw_pkg::DATA_W-1:0] edge_type,
      input logic [gbmw_pkg::DATA_W-1:0] both,
      input logic [gbmw_pkg::DATA_W-1:0] polarity,
      input logic [gbmw_pkg::DATA_W-1:0] latched
   );
      logic [gbmw_pkg::DATA_W-1:0] edge_pins;
      edge_pins  = edge_type | both;
      raw_status = (latched & edge_pins & enable)
                 | (~edge_pins & enable & ~(pins ^ polarity));
   endfunction

   function automatic logic [gbmw_pkg::DATA_W-1:0] masked_write(
      input logic                        sel,
      input logic [gbmw_pkg::DATA_W-1:0] old_value,
      input logic [gbmw_pkg::DATA_W-1:0] enable,
      input logic [gbmw_pkg::DATA_W-1:0] data
   );
      masked_write = sel ? ((old_value & ~enable) | (data & enable)) : old_value;
   endfunction

   assign aligned   = (item.address[1:0] == 2'b00);
   assign base_addr = {item.address[gbmw_pkg::ADDR_W-1:3], 3'b000};
   assign is_write  = (item.opcode == gbmw_pkg::OP_WRITE) && aligned;

   assign we    = item.address[2]
                ? {item.write_data[gbmw_pkg::DATA_W-1:gbmw_pkg::HALF_W],
                   {gbmw_pkg::HALF_W{1'b0}}}
                : {{gbmw_pkg::HALF_W{1'b0}},
                   item.write_data[gbmw_pkg::DATA_W-1:gbmw_pkg::HALF_W]};
   assign wdata = item.address[2]
                ? {item.write_data[gbmw_pkg::HALF_W-1:0], {gbmw_pkg::HALF_W{1'b0}}}
                : {{gbmw_pkg::HALF_W{1'b0}}, item.write_data[gbmw_pkg::HALF_W-1:0]};

   assign old_raw = raw_status(item.pin_in, irq_enable_ff, edge_type_ff, both_edges_ff,
                               polarity_ff, edge_latched_ff);

   always_comb begin
      half_word = '0;
      unique case (base_addr)
         gbmw_pkg::ADDR_OUT_LEVEL:  half_word = out_level_ff;
         gbmw_pkg::ADDR_DIRECTION:  half_word = direction_ff;
         gbmw_pkg::ADDR_IRQ_ENABLE: half_word = irq_enable_ff;
         gbmw_pkg::ADDR_IRQ_MASK:   half_word = irq_mask_ff;
         gbmw_pkg::ADDR_EDGE_TYPE:  half_word = edge_type_ff;
         gbmw_pkg::ADDR_POLARITY:   half_word = polarity_ff;
         gbmw_pkg::ADDR_BOTH_EDGES: half_word = both_edges_ff;
         default:                   half_word = '0;
      endcase
   end

   always_comb begin
      read_value = '0;
      if ((item.opcode == gbmw_pkg::OP_READ) && aligned) begin
         unique case (item.address)
            gbmw_pkg::ADDR_STATUS:     read_value = old_raw & ~irq_mask_ff;
            gbmw_pkg::ADDR_RAW_STATUS: read_value = old_raw;
            gbmw_pkg::ADDR_PINS:       read_value = item.pin_in;
            gbmw_pkg::ADDR_VERSION:    read_value = gbmw_pkg::VERSION_WORD;
            default: begin
               read_value = item.address[2]
                          ? {{gbmw_pkg::HALF_W{1'b0}},
                             half_word[gbmw_pkg::DATA_W-1:gbmw_pkg::HALF_W]}
                          : {{gbmw_pkg::HALF_W{1'b0}}, half_word[gbmw_pkg::HALF_W-1:0]};
            end
         endcase
      end
   end

   always_comb begin
      out_level_in  = masked_write(is_write && (base_addr == gbmw_pkg::ADDR_OUT_LEVEL),
                                   out_level_ff, we, wdata);
      direction_in  = masked_write(is_write && (base_addr == gbmw_pkg::ADDR_DIRECTION),
                                   direction_ff, we, wdata);
      irq_enable_in = masked_write(is_write && (base_addr == gbmw_pkg::ADDR_IRQ_ENABLE),
                                   irq_enable_ff, we, wdata);
      irq_mask_in   = masked_write(is_write && (base_addr == gbmw_pkg::ADDR_IRQ_MASK),
                                   irq_mask_ff, we, wdata);
      edge_type_in  = masked_write(is_write && (base_addr == gbmw_pkg::ADDR_EDGE_TYPE),
                                   edge_type_ff, we, wdata);
      polarity_in   = masked_write(is_write && (base_addr == gbmw_pkg::ADDR_POLARITY),
                                   polarity_ff, we, wdata);
      both_edges_in = masked_write(is_write && (base_addr == gbmw_pkg::ADDR_BOTH_EDGES),
                                   both_edges_ff, we, wdata);
      eoi_cleared   = (is_write && (base_addr == gbmw_pkg::ADDR_EOI))
                    ? (edge_latched_ff & ~(wdata & we)) : edge_latched_ff;

      rise = item.pin_in & ~previous_pins_ff;
      fall = ~item.pin_in & previous_pins_ff;
      hits = (both_edges_in & (rise | fall))
           | (~both_edges_in & polarity_in & rise)
           | (~both_edges_in & ~polarity_in & fall);
      new_edge_pins    = edge_type_in | both_edges_in;
      edge_latched_in  = eoi_cleared | (hits & new_edge_pins & irq_enable_in);
      previous_pins_in = item.pin_in;

      new_raw = raw_status(item.pin_in, irq_enable_in, edge_type_in, both_edges_in,
                           polarity_in, edge_latched_in);
   end

   assign result.read_data = read_value;
   assign result.pin_out   = out_level_in;
   assign result.pin_dir   = direction_in;
   assign result.irq       = |(new_raw & ~irq_mask_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_level_ff     <= '0;
         direction_ff     <= '0;
         irq_enable_ff    <= '0;
         irq_mask_ff      <= '0;
         edge_type_ff     <= '0;
         polarity_ff      <= '0;
         both_edges_ff    <= '0;
         edge_latched_ff  <= '0;
         previous_pins_ff <= '0;
      end else if (advance) begin
         out_level_ff     <= out_level_in;
         direction_ff     <= direction_in;
         irq_enable_ff    <= irq_enable_in;
         irq_mask_ff      <= irq_mask_in;
         edge_type_ff     <= edge_type_in;
         polarity_ff      <= polarity_in;
         both_edges_ff    <= both_edges_in;
         edge_latched_ff  <= edge_latched_in;
         previous_pins_ff <= previous_pins_in;
      end
   end

endmodule

>>> design/gpio_bank_masked_write_irq_unit.sv
// A taken request waits in the input register until the result register is free, then
// moves into it and raises rsp_valid; the result register frees as the response is taken.
// Throughput: one transaction per cycle while rsp_stall is low.
// Each transaction updates the bank state in the cycle it moves into the result register.
// Reset: synchronous, active high; clears all bank registers and both valid flags.
module gpio_bank_masked_write_irq_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  gbmw_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output gbmw_pkg::rsp_type rsp_data
);

   logic              in_valid_ff;
   gbmw_pkg::req_type in_data_ff;
   logic              rsp_valid_ff;
   gbmw_pkg::rsp_type rsp_data_ff;
   gbmw_pkg::rsp_type result;
   logic              advance;
   logic              req_take;

   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   gbmw_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (in_data_ff),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_take_when_full: assert property (@(posedge clock) disable iff (reset)
      (req_take && in_valid_ff) |-> advance)
      else $error("request taken over an unmoved transaction");
   a_advance_fills: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid)
      else $error("advanced transaction lost");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("stalled response dropped");
`endif

endmodule
